@@ sv/mrpt_pkg.sv @@
// ---------------------------------------------------------------------------
// mrpt_pkg
// Shared widths, base and bound tables and the controller state type for the
// Miller-Rabin prime test unit.
// ---------------------------------------------------------------------------
package mrpt_pkg;

  localparam int unsigned NumW    = 63;
  localparam int unsigned CntW    = 6;
  localparam int unsigned BaseW   = 6;
  localparam int unsigned NumBase = 12;
  localparam int unsigned IdxW    = 4;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumBase - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECOMP,
    ST_BRED,
    ST_NORM,
    ST_ISSUE_SQ,
    ST_WAIT_SQ,
    ST_ISSUE_MB,
    ST_WAIT_MB,
    ST_ADVANCE,
    ST_CHECK,
    ST_ISSUE_SS,
    ST_WAIT_SS,
    ST_SSCHK,
    ST_PASS,
    ST_FIN
  } mrpt_state_e;

  function automatic logic [BaseW-1:0] test_base(input logic [IdxW-1:0] k);
    logic [BaseW-1:0] b;
    unique case (k)
      4'd0:    b = 6'd2;
      4'd1:    b = 6'd3;
      4'd2:    b = 6'd5;
      4'd3:    b = 6'd7;
      4'd4:    b = 6'd11;
      4'd5:    b = 6'd13;
      4'd6:    b = 6'd17;
      4'd7:    b = 6'd19;
      4'd8:    b = 6'd23;
      4'd9:    b = 6'd29;
      4'd10:   b = 6'd31;
      4'd11:   b = 6'd37;
      default: b = 6'd2;
    endcase
    return b;
  endfunction

  // exclusive bound proven after passing bases 0..k, zero means no early stop
  function automatic logic [NumW-1:0] stop_bound(input logic [IdxW-1:0] k);
    logic [NumW-1:0] v;
    unique case (k)
      4'd1:    v = 63'd1373653;
      4'd2:    v = 63'd25326001;
      4'd3:    v = 63'd3215031751;
      4'd4:    v = 63'd2152302898747;
      4'd5:    v = 63'd3474749660383;
      4'd6:    v = 63'd341550071728321;
      4'd8:    v = 63'd3825123056546413051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/mrpt_modmul.sv @@
// ---------------------------------------------------------------------------
// mrpt_modmul
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle,
// msb first, double-and-add with conditional subtraction of the modulus.
// ---------------------------------------------------------------------------
module mrpt_modmul import mrpt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] x_i,
  input  logic [NumW-1:0] y_i,
  input  logic [NumW-1:0] m_i,
  output logic            done_o,
  output logic [NumW-1:0] prod_o
);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] x_q, x_d;
  logic [NumW-1:0] y_q, y_d;
  logic [NumW-1:0] m_q, m_d;
  logic [NumW-1:0] acc_q, acc_d;

  logic [NumW:0]   dbl, dbl_red, add, add_red;

  always_comb begin
    dbl     = {acc_q, 1'b0};
    dbl_red = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    add     = dbl_red + {1'b0, x_q};
    add_red = (add >= {1'b0, m_q}) ? add - {1'b0, m_q} : add;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    m_d    = m_q;
    acc_d  = acc_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      x_d    = x_i;
      y_d    = y_i;
      m_d    = m_i;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = y_q[NumW-1] ? add_red[NumW-1:0] : dbl_red[NumW-1:0];
      y_d   = {y_q[NumW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    m_q   <= m_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

@@ sv/miller_rabin_prime_test_unit.sv @@
// ---------------------------------------------------------------------------
// miller_rabin_prime_test_unit
// Deterministic Miller-Rabin test of a 63-bit number against bases 2 to 37,
// with early exit at the proven bounds, on one shared bit-serial multiplier.
// ---------------------------------------------------------------------------
// every modular product runs through the shared bit-serial multiplier; each base
// needs at most about 125 products, up to twelve bases per number; numbers
// below 4 skip the test, and even ones stop after one base
// throughput: one number at a time; the next is taken once the result is staged
// reset: asynchronous active low, returns to idle with no result pending
module miller_rabin_prime_test_unit import mrpt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [NumW-1:0] number_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            is_prime_o
);

  mrpt_state_e      state_q, state_d;
  logic [NumW-1:0]  n_q, n_d;
  logic [NumW-1:0]  nm1_q, nm1_d;
  logic [NumW-1:0]  d_q, d_d;
  logic [NumW-1:0]  e_q, e_d;
  logic [NumW-1:0]  x_q, x_d;
  logic [CntW-1:0]  s_q, s_d;
  logic [CntW-1:0]  ebits_q, ebits_d;
  logic [CntW:0]    r_q, r_d;
  logic [BaseW-1:0] b_q, b_d;
  logic [IdxW-1:0]  k_q, k_d;
  logic             res_q, res_d;
  logic             out_valid_q, out_valid_d;
  logic             prime_q, prime_d;

  logic            accept;
  logic            mm_start;
  logic [NumW-1:0] mm_y;
  logic            mm_done;
  logic [NumW-1:0] mm_prod;
  logic            b_ge_n;
  logic            x_pass;
  logic [NumW-1:0] bound;
  logic            early_stop;
  logic            out_free;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign b_ge_n     = {{(NumW-BaseW){1'b0}}, b_q} >= n_q;
  assign x_pass     = (x_q == NumW'(1)) || (x_q == nm1_q);
  assign bound      = stop_bound(k_q);
  assign early_stop = (bound != '0) && (n_q < bound);
  assign out_free   = !out_valid_q || !out_stall_i;

  mrpt_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start),
    .x_i    (x_q),
    .y_i    (mm_y),
    .m_i    (n_q),
    .done_o (mm_done),
    .prod_o (mm_prod)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (number_i < NumW'(4)) ? ST_FIN : ST_DECOMP;
        end
      end
      ST_DECOMP: begin
        if (nm1_q[0] ? 1'b1 : e_q[0]) state_d = ST_BRED;
      end
      ST_BRED:     if (!b_ge_n) state_d = ST_NORM;
      ST_NORM:     if (e_q[NumW-1]) state_d = ST_ISSUE_SQ;
      ST_ISSUE_SQ: state_d = ST_WAIT_SQ;
      ST_WAIT_SQ: begin
        if (mm_done) state_d = e_q[NumW-1] ? ST_ISSUE_MB : ST_ADVANCE;
      end
      ST_ISSUE_MB: state_d = ST_WAIT_MB;
      ST_WAIT_MB:  if (mm_done) state_d = ST_ADVANCE;
      ST_ADVANCE:  state_d = (ebits_q == CntW'(1)) ? ST_CHECK : ST_ISSUE_SQ;
      ST_CHECK: begin
        if (x_pass) state_d = ST_PASS;
        else if (s_q > CntW'(1)) state_d = ST_ISSUE_SS;
        else state_d = ST_FIN;
      end
      ST_ISSUE_SS: state_d = ST_WAIT_SS;
      ST_WAIT_SS:  if (mm_done) state_d = ST_SSCHK;
      ST_SSCHK: begin
        if (x_q == nm1_q) state_d = ST_PASS;
        else if ((r_q + 1'b1) < {1'b0, s_q}) state_d = ST_ISSUE_SS;
        else state_d = ST_FIN;
      end
      ST_PASS: begin
        if (early_stop || (k_q == LastIdx)) state_d = ST_FIN;
        else state_d = ST_BRED;
      end
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    n_d         = n_q;
    nm1_d       = nm1_q;
    d_d         = d_q;
    e_d         = e_q;
    x_d         = x_q;
    s_d         = s_q;
    ebits_d     = ebits_q;
    r_d         = r_q;
    b_d         = b_q;
    k_d         = k_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    prime_d     = prime_q;
    mm_start    = 1'b0;
    mm_y        = x_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          n_d   = number_i;
          nm1_d = number_i - 1'b1;
          e_d   = number_i - 1'b1;
          s_d   = '0;
          k_d   = '0;
          b_d   = test_base('0);
          res_d = (number_i >= NumW'(2));
        end
      end
      ST_DECOMP: begin
        if (!e_q[0]) begin
          e_d = {1'b0, e_q[NumW-1:1]};
          s_d = s_q + 1'b1;
        end else begin
          d_d = e_q;
        end
      end
      ST_BRED: begin
        if (b_ge_n) begin
          b_d = b_q - n_q[BaseW-1:0];
        end else begin
          ebits_d = CntW'(NumW);
          x_d     = NumW'(1);
        end
      end
      ST_NORM: begin
        if (!e_q[NumW-1]) begin
          e_d     = {e_q[NumW-2:0], 1'b0};
          ebits_d = ebits_q - 1'b1;
        end
      end
      ST_ISSUE_SQ: mm_start = 1'b1;
      ST_WAIT_SQ:  if (mm_done) x_d = mm_prod;
      ST_ISSUE_MB: begin
        mm_start = 1'b1;
        mm_y     = {{(NumW-BaseW){1'b0}}, b_q};
      end
      ST_WAIT_MB:  if (mm_done) x_d = mm_prod;
      ST_ADVANCE: begin
        e_d     = {e_q[NumW-2:0], 1'b0};
        ebits_d = ebits_q - 1'b1;
      end
      ST_CHECK: begin
        r_d = (CntW+1)'(1);
        if (!x_pass && !(s_q > CntW'(1))) res_d = 1'b0;
      end
      ST_ISSUE_SS: mm_start = 1'b1;
      ST_WAIT_SS:  if (mm_done) x_d = mm_prod;
      ST_SSCHK: begin
        r_d = r_q + 1'b1;
        if ((x_q != nm1_q) && !((r_q + 1'b1) < {1'b0, s_q})) res_d = 1'b0;
      end
      ST_PASS: begin
        if (!(early_stop || (k_q == LastIdx))) begin
          k_d = k_q + 1'b1;
          b_d = test_base(k_q + 1'b1);
          e_d = d_q;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          prime_d     = res_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    nm1_q   <= nm1_d;
    d_q     <= d_d;
    e_q     <= e_d;
    x_q     <= x_d;
    s_q     <= s_d;
    ebits_q <= ebits_d;
    r_q     <= r_d;
    b_q     <= b_d;
    k_q     <= k_d;
    res_q   <= res_d;
    prime_q <= prime_d;
  end

  assign out_valid_o = out_valid_q;
  assign is_prime_o  = prime_q;

endmodule

@@ dv/prime_result_monitor.sv @@
// ---------------------------------------------------------------------------
// prime_result_monitor
// Watches the number and result channels of the prime test unit. For every
// accepted number it works out the expected verdict with its own
// strong-probable-prime test and queues it. Each accepted result is then
// compared against the oldest queued verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_result_monitor import mrpt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  logic [NumW-1:0] number_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  logic            is_prime_i,
  output int              fail_count_o,
  output int              pending_o
);

  localparam int unsigned WitnessCount = 12;
  localparam int          ShownLimit   = 10;

  bit expected_verdicts[$];
  int fails;
  int shown;

  function automatic logic [63:0] witness(input int unsigned k);
    logic [63:0] w;
    case (k)
      0:       w = 64'd2;
      1:       w = 64'd3;
      2:       w = 64'd5;
      3:       w = 64'd7;
      4:       w = 64'd11;
      5:       w = 64'd13;
      6:       w = 64'd17;
      7:       w = 64'd19;
      8:       w = 64'd23;
      9:       w = 64'd29;
      10:      w = 64'd31;
      default: w = 64'd37;
    endcase
    return w;
  endfunction

  // numbers below this bound are proven prime once witnesses 0..k pass
  function automatic logic [63:0] proven_below(input int unsigned k);
    logic [63:0] v;
    case (k)
      1:       v = 64'd1373653;
      2:       v = 64'd25326001;
      3:       v = 64'd3215031751;
      4:       v = 64'd2152302898747;
      5:       v = 64'd3474749660383;
      6:       v = 64'd341550071728321;
      8:       v = 64'd3825123056546413051;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] mulmod(input logic [63:0] x, input logic [63:0] y,
                                         input logic [63:0] m);
    logic [63:0] acc;
    acc = '0;
    for (int i = NumW - 1; i >= 0; i--) begin
      acc = acc + acc;
      if (acc >= m) acc = acc - m;
      if (y[i]) begin
        acc = acc + x;
        if (acc >= m) acc = acc - m;
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] powmod(input logic [63:0] b, input logic [63:0] e,
                                         input logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] rest;
    acc  = 64'd1 % m;
    sq   = b % m;
    rest = e;
    while (rest != 0) begin
      if (rest[0]) acc = mulmod(acc, sq, m);
      sq   = mulmod(sq, sq, m);
      rest = rest >> 1;
    end
    return acc;
  endfunction

  function automatic bit witness_passes(input logic [63:0] n, input logic [63:0] b);
    logic [63:0] d;
    logic [63:0] x;
    int unsigned s;
    d = n - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    x = powmod(b, d, n);
    if (x == 1 || x == n - 1) return 1'b1;
    for (int unsigned r = 1; r < s; r++) begin
      x = mulmod(x, x, n);
      if (x == n - 1) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit prime_expected(input logic [NumW-1:0] num);
    logic [63:0] n;
    n = {1'b0, num};
    if (n < 2) return 1'b0;
    if (n < 4) return 1'b1;
    for (int unsigned k = 0; k < WitnessCount; k++) begin
      if (!witness_passes(n, witness(k))) return 1'b0;
      if (proven_below(k) != 0 && n < proven_below(k)) return 1'b1;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bit want;
    if (!rst_ni) begin
      expected_verdicts.delete();
      fails        = 0;
      shown        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_verdicts.size() == 0) begin
          fails++;
          if (shown < ShownLimit) begin
            shown++;
            $display("[%0t] unexpected result beat: is_prime=%0b", $realtime, is_prime_i);
          end
        end else begin
          want = expected_verdicts.pop_front();
          if (is_prime_i !== want) begin
            fails++;
            if (shown < ShownLimit) begin
              shown++;
              $display("[%0t] is_prime mismatch: expected %0b, got %0b",
                       $realtime, want, is_prime_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_verdicts.push_back(prime_expected(number_i));
      fail_count_o <= fails;
      pending_o    <= expected_verdicts.size();
    end
  end

endmodule

@@ dv/tb_miller_rabin_prime_test_unit.sv @@
// ---------------------------------------------------------------------------
// tb_miller_rabin_prime_test_unit
// Drives numbers into the prime test unit: a directed set of edge values,
// strong pseudoprimes and large primes, then random numbers biased toward
// small primes and cheap composites, with a few at full width. Input beats
// come in random bursts and the result side stalls in changing patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_miller_rabin_prime_test_unit;
  import mrpt_pkg::*;

  localparam int unsigned     RandomCount = 77;
  localparam longint unsigned CycleLimit  = 64'd50_000_000;
  localparam int unsigned     DrainCycles = 300;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_HEAVY
  } stall_mode_e;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic [NumW-1:0] number    = '0;
  logic            out_stall = 1'b0;
  logic            in_stall;
  logic            out_valid;
  logic            is_prime;
  int              fail_count;
  int              pending;
  longint unsigned cycles      = 0;
  int unsigned     burst_left  = 0;
  int unsigned     stall_left  = 0;
  stall_mode_e     stall_mode  = STALL_NONE;

  always #5 clk = ~clk;

  miller_rabin_prime_test_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .number_i    (number),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .is_prime_o  (is_prime)
  );

  prime_result_monitor u_monitor (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .number_i     (number),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .is_prime_i   (is_prime),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 2));
      stall_left <= $urandom_range(50, 3000);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_COIN: out_stall <= ($urandom_range(0, 1) == 1);
      default:    out_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  task automatic send(input logic [NumW-1:0] n);
    int unsigned gap;
    in_valid <= 1'b1;
    number   <= n;
    do @(posedge clk); while (in_stall);
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 30);
      burst_left = $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [NumW-1:0] pick_number();
    int unsigned kind;
    int unsigned width;
    logic [63:0] raw;
    logic [NumW-1:0] n;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      width = $urandom_range(2, 20);
      do begin
        raw = {$urandom, $urandom};
        n   = NumW'((raw >> (64 - width)) | (64'd1 << (width - 1)) | 64'd1);
      end while (!u_monitor.prime_expected(n));
    end else begin
      if (kind < 70)      width = $urandom_range(2, 16);
      else if (kind < 85) width = $urandom_range(17, 40);
      else if (kind < 93) width = NumW;
      else                width = $urandom_range(41, NumW - 1);
      raw = {$urandom, $urandom};
      n   = NumW'(raw >> (64 - width));
    end
    return n;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(63'd0);
    send(63'd1);
    send(63'd2);
    send(63'd3);
    send(63'd4);
    send(63'd5);
    send(63'd9);
    send(63'd25);
    send(63'd97);
    send(63'd561);
    send(63'd2047);
    send(63'd65537);
    send(63'd1373653);
    send(63'd25326001);
    send(63'd3215031751);
    send(63'd4294967297);
    send(63'd341550071728321);
    send(63'd2305843009213693951);
    send(63'd3825123056546413051);
    send(63'd4611686018427387904);
    send(63'd9223372036854775806);
    send(63'd9223372036854775807);
    send(63'd9223372036854775783);

    for (int i = 0; i < RandomCount; i++) send(pick_number());
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
